// ===== src/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants for the TTL keyed range cache
// Entry layout, widths, operation codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int ENTRIES = 128;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W   = 32;
   localparam int RANGE_W = 64;
   localparam int NOW_W   = 63;
   localparam int AGE_W   = 32;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(2000);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [RANGE_W-1:0] base;
      logic [RANGE_W-1:0] size;
      logic [NOW_W-1:0]   stamp;
   } trc_entry_type;

   localparam int ENTRY_W = $bits(trc_entry_type);

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture request, clear result and scan pipeline
      logic write;        // store request into the slot under the pointer
      logic scan_rd;      // read slot at scan address, advance scan address
      logic scan_active;  // hits may be captured
   } trc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_store;
      logic key_zero;
      logic addr_last;
      logic pipe_empty;
      logic hit;
   } trc_sts_type;

endpackage

// ===== src/trc_ram.sv =====
// ----------------------------------------------------------------------------
// trc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module trc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/trc_ctrl.sv =====
// ----------------------------------------------------------------------------
// trc_ctrl: sequencer for the TTL keyed range cache
// Dispatches stores and lookups, runs the slot scan and issues the result.
// ----------------------------------------------------------------------------
module trc_ctrl
   import trc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output trc_cmd_type cmd,
   input  trc_sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SCAN     = 5'b00100,
      S_DRAIN    = 5'b01000,
      S_RESP     = 5'b10000
   } trc_state_type;

   trc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.is_store || sts.key_zero) begin
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               state_in = S_RESP;
            end else if (sts.addr_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.hit || sts.pipe_empty) begin
               state_in = S_RESP;
            end
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.load        = (state_ff == S_IDLE) && start;
      cmd.write       = (state_ff == S_DISPATCH) && sts.is_store;
      cmd.scan_rd     = (state_ff == S_SCAN);
      cmd.scan_active = (state_ff == S_SCAN) || (state_ff == S_DRAIN);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ===== src/trc_datapath.sv =====
// ----------------------------------------------------------------------------
// trc_datapath: slot store, round-robin pointer and scan compare pipeline
// Slot RAM read -> key/age stage -> freshness check and result capture.
// ----------------------------------------------------------------------------
module trc_datapath
   import trc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  trc_cmd_type        cmd,
   output trc_sts_type        sts,
   input  logic               req_operation,
   input  logic [KEY_W-1:0]   req_process_key,
   input  logic [RANGE_W-1:0] req_image_base,
   input  logic [RANGE_W-1:0] req_image_size,
   input  logic [NOW_W-1:0]   req_now_ticks,
   input  logic               csr_wr,
   input  logic [AGE_W-1:0]   csr_data,
   output logic               hit,
   output logic [RANGE_W-1:0] found_base,
   output logic [RANGE_W-1:0] found_size
);

   // captured request
   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [RANGE_W-1:0] base_ff, size_ff;
   logic [NOW_W-1:0]   now_ff;

   logic [AGE_W-1:0]   max_age_ff, max_age_in;
   logic [IDX_W-1:0]   next_slot_ff, next_slot_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;

   // stage 1: RAM data
   logic               rd_vld_ff, rd_vld_in;
   logic               vbit_ff, vbit_in;
   // stage 2: match and age
   logic               s2_vld_ff, s2_vld_in;
   logic               s2_match_ff, s2_match_in;
   logic [RANGE_W-1:0] s2_diff_ff, s2_diff_in;
   logic [RANGE_W-1:0] s2_base_ff, s2_size_ff;
   // result
   logic               hit_ff, hit_in;
   logic [RANGE_W-1:0] fbase_ff, fbase_in, fsize_ff, fsize_in;

   trc_entry_type wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic store_ok, write_en, hit_now;

   assign store_ok = (key_ff != '0) && (base_ff != '0) && (size_ff != '0);
   assign write_en = cmd.write && (op_ff == OP_STORE) && store_ok;

   always_comb begin
      wr_entry.key   = key_ff;
      wr_entry.base  = base_ff;
      wr_entry.size  = size_ff;
      wr_entry.stamp = now_ff;
   end

   trc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (write_en),
      .wr_addr (next_slot_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   // freshness: no borrow (stamp not later than now) and age within limit
   assign hit_now = s2_vld_ff && s2_match_ff && !s2_diff_ff[RANGE_W-1] &&
                    (s2_diff_ff[NOW_W-1:0] <= NOW_W'(max_age_ff));

   always_comb begin
      max_age_in = csr_wr ? csr_data : max_age_ff;

      valid_in     = valid_ff;
      next_slot_in = next_slot_ff;
      if (write_en) begin
         valid_in[next_slot_ff] = 1'b1;
         if (next_slot_ff == IDX_W'(ENTRIES - 1)) begin
            next_slot_in = '0;
         end else begin
            next_slot_in = next_slot_ff + 1'b1;
         end
      end

      scan_addr_in = scan_addr_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
      end else if (cmd.scan_rd) begin
         if (scan_addr_ff == IDX_W'(ENTRIES - 1)) begin
            scan_addr_in = '0;
         end else begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
      end

      rd_vld_in = cmd.scan_rd && !cmd.load;
      vbit_in   = valid_ff[scan_addr_ff];

      s2_vld_in   = rd_vld_ff && !cmd.load;
      s2_match_in = vbit_ff && (rd_entry.key == key_ff) &&
                    (rd_entry.base != '0) && (rd_entry.size != '0) &&
                    (rd_entry.stamp != '0);
      s2_diff_in  = {1'b0, now_ff} - {1'b0, rd_entry.stamp};

      hit_in   = hit_ff;
      fbase_in = fbase_ff;
      fsize_in = fsize_ff;
      if (cmd.load) begin
         hit_in   = 1'b0;
         fbase_in = '0;
         fsize_in = '0;
      end else if (cmd.scan_active && hit_now) begin
         hit_in   = 1'b1;
         fbase_in = s2_base_ff;
         fsize_in = s2_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= MAX_AGE_RESET;
         valid_ff     <= '0;
         next_slot_ff <= '0;
         rd_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         max_age_ff   <= max_age_in;
         valid_ff     <= valid_in;
         next_slot_ff <= next_slot_in;
         rd_vld_ff    <= rd_vld_in;
         s2_vld_ff    <= s2_vld_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= req_process_key;
         base_ff <= req_image_base;
         size_ff <= req_image_size;
         now_ff  <= req_now_ticks;
      end
      scan_addr_ff <= scan_addr_in;
      vbit_ff      <= vbit_in;
      s2_match_ff  <= s2_match_in;
      s2_diff_ff   <= s2_diff_in;
      s2_base_ff   <= rd_entry.base;
      s2_size_ff   <= rd_entry.size;
      fbase_ff     <= fbase_in;
      fsize_ff     <= fsize_in;
   end

   always_comb begin
      sts.is_store   = (op_ff == OP_STORE);
      sts.key_zero   = (key_ff == '0);
      sts.addr_last  = (scan_addr_ff == IDX_W'(ENTRIES - 1));
      sts.pipe_empty = !rd_vld_ff && !s2_vld_ff;
      sts.hit        = hit_now;
   end

   assign hit        = hit_ff;
   assign found_base = fbase_ff;
   assign found_size = fsize_ff;

endmodule

// ===== src/ttl_keyed_range_cache.sv =====
// ----------------------------------------------------------------------------
// ttl_keyed_range_cache: round-robin cache of key -> (base, size) with age
// Stores ranges per process key and returns the first fresh match on lookup.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------
//  request   start, busy (in on !busy)  req_operation, req_process_key,
//                                       req_image_base, req_image_size,
//                                       req_now_ticks
//  response  rsp_valid (1-cycle strobe) rsp_hit, rsp_found_base,
//                                       rsp_found_size
//  csr       csr_valid, csr_ready       csr_max_age_ticks
//
// Sequence: a store answers through the dispatch and response states and the
//   block is free again after the response; a zero-key lookup does the same.
//   A lookup scans the slot RAM one slot per cycle through its single read
//   port; a miss scans every slot, while a hit on slot i ends the scan early.
// Reset: synchronous, active high; per-slot valid flops clear the whole
//   store at once, max age returns to 2000 ticks. No clearing pass.
// Stalls: one item at a time; busy stays high until the result strobe has
//   passed. The receiver cannot stall the result.
//
module ttl_keyed_range_cache
   import trc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [KEY_W-1:0]   req_process_key,
   input  logic [RANGE_W-1:0] req_image_base,
   input  logic [RANGE_W-1:0] req_image_size,
   input  logic [NOW_W-1:0]   req_now_ticks,
   // response
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [RANGE_W-1:0] rsp_found_base,
   output logic [RANGE_W-1:0] rsp_found_size,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [AGE_W-1:0]   csr_max_age_ticks
);

   trc_cmd_type cmd;
   trc_sts_type sts;

   // single register, always writable; writes must come only while idle, which the block itself does not enforce
   assign csr_ready = 1'b1;

   trc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // result registers are cleared when an item is taken, so stores,
   // zero-key lookups and misses all report zeros
   trc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_process_key (req_process_key),
      .req_image_base  (req_image_base),
      .req_image_size  (req_image_size),
      .req_now_ticks   (req_now_ticks),
      .csr_wr          (csr_valid && csr_ready),
      .csr_data        (csr_max_age_ticks),
      .hit             (rsp_hit),
      .found_base      (rsp_found_base),
      .found_size      (rsp_found_size)
   );

endmodule

// ===== src/trc_checker.sv =====
// ----------------------------------------------------------------------------
// trc_checker: port-level checks for the TTL keyed range cache
// Bound to the top level; watches request, response and result payload.
// ----------------------------------------------------------------------------
module trc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic [63:0] rsp_found_base,
   input logic [63:0] rsp_found_size
);

   // result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held more than one cycle");

   // a result only comes while an item is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result without item in flight");

   // a store answers through the dispatch and response states, always as a miss
   a_store_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation) |-> ##2 (rsp_valid && !rsp_hit))
      else $error("store result late or reported a hit");

   // a hit returns a stored, nonempty range
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_found_base != 64'd0 && rsp_found_size != 64'd0))
      else $error("hit with empty range");

endmodule

bind ttl_keyed_range_cache trc_checker u_trc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_found_base (rsp_found_base),
   .rsp_found_size (rsp_found_size)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ttl_keyed_range_cache
// Drives store and lookup items through the start/busy port, keeps its own
// copy of the slot store and max age register, predicts the answer to every
// accepted item and compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import trc_pkg::*;

   localparam int STALL_LIMIT = 20 * (ENTRIES + 50);   // cycles with no progress
   localparam logic [NOW_W-1:0]   NOW_TOP   = {NOW_W{1'b1}};
   localparam logic [RANGE_W-1:0] RANGE_TOP = {RANGE_W{1'b1}};
   localparam logic [KEY_W-1:0]   KEY_TOP   = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0]   KEY_A     = 32'h0000_1234;
   localparam logic [KEY_W-1:0]   KEY_B     = 32'h8000_0001;
   localparam logic [KEY_W-1:0]   KEY_C     = 32'h5A5A_A5A5;

   // one expected answer per item
   typedef struct packed {
      logic               hit;
      logic [RANGE_W-1:0] base;
      logic [RANGE_W-1:0] size;
   } range_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               start             = 1'b0;
   logic               busy;
   logic               req_operation     = OP_LOOKUP;
   logic [KEY_W-1:0]   req_process_key   = '0;
   logic [RANGE_W-1:0] req_image_base    = '0;
   logic [RANGE_W-1:0] req_image_size    = '0;
   logic [NOW_W-1:0]   req_now_ticks     = '0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [RANGE_W-1:0] rsp_found_base;
   logic [RANGE_W-1:0] rsp_found_size;
   logic               csr_valid         = 1'b0;
   logic               csr_ready;
   logic [AGE_W-1:0]   csr_max_age_ticks = '0;

   // shadow copy of the cache
   logic [KEY_W-1:0]   shadow_key   [ENTRIES];
   logic [RANGE_W-1:0] shadow_base  [ENTRIES];
   logic [RANGE_W-1:0] shadow_size  [ENTRIES];
   logic [NOW_W-1:0]   shadow_stamp [ENTRIES];
   int                 shadow_next;
   logic [AGE_W-1:0]   shadow_max_age;

   range_answer_type   pending_answers [$];

   // bookkeeping for the summary
   int stores_written   = 0;
   int stores_dropped   = 0;
   int lookups_issued   = 0;
   int lookups_hit      = 0;
   int answers_checked  = 0;
   int age_writes       = 0;
   int mismatch_count   = 0;
   int stall_cycles     = 0;

   logic [NOW_W-1:0] tick_now = '0;
   bit   quiet_stretch = 1'b0;   // no sender gaps while set

   always #10 clock = ~clock;

   ttl_keyed_range_cache dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_process_key   (req_process_key),
      .req_image_base    (req_image_base),
      .req_image_size    (req_image_size),
      .req_now_ticks     (req_now_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_found_base    (rsp_found_base),
      .rsp_found_size    (rsp_found_size),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_age_ticks (csr_max_age_ticks)
   );

   // -------------------------------------------------------------------------
   // Shadow cache: applies one item and returns the answer the block owes.
   // Stores go to the round-robin slot; a lookup takes the lowest slot that
   // is occupied, keyed the same, holds a real range and is not too old.
   // -------------------------------------------------------------------------
   function automatic range_answer_type resolve_range(
         input logic               op,
         input logic [KEY_W-1:0]   key,
         input logic [RANGE_W-1:0] base,
         input logic [RANGE_W-1:0] size,
         input logic [NOW_W-1:0]   now);
      range_answer_type ans;
      ans = '0;
      if (op == OP_STORE) begin
         if (key != '0 && base != '0 && size != '0) begin
            // a store at tick zero lands with a zero stamp: reads as empty
            shadow_key[shadow_next]   = key;
            shadow_base[shadow_next]  = base;
            shadow_size[shadow_next]  = size;
            shadow_stamp[shadow_next] = now;
            shadow_next = (shadow_next + 1) % ENTRIES;
            stores_written++;
         end else begin
            stores_dropped++;
         end
      end else begin
         lookups_issued++;
         if (key != '0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               // stamp ahead of now means a negative age: skip the slot
               if (shadow_stamp[i] != '0 && shadow_key[i] == key &&
                   shadow_base[i] != '0 && shadow_size[i] != '0 &&
                   now >= shadow_stamp[i] &&
                   (now - shadow_stamp[i]) <= NOW_W'(shadow_max_age)) begin
                  ans.hit  = 1'b1;
                  ans.base = shadow_base[i];
                  ans.size = shadow_size[i];
                  lookups_hit++;
                  break;
               end
            end
         end
      end
      return ans;
   endfunction

   // Sender gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_stretch || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Send one item. Called just after a rising edge; returns at the edge that
   // took the item. start is left high so back-to-back items need no toggle.
   // -------------------------------------------------------------------------
   task automatic send_item(
         input logic               op,
         input logic [KEY_W-1:0]   key,
         input logic [RANGE_W-1:0] base,
         input logic [RANGE_W-1:0] size,
         input logic [NOW_W-1:0]   now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_process_key <= key;
      req_image_base  <= base;
      req_image_size  <= size;
      req_now_ticks   <= now;
      // busy read here is the value seen by the edge
      do @(posedge clock); while (busy);
      pending_answers.push_back(resolve_range(op, key, base, size, now));
   endtask

   // Register write: only with the block drained and quiet.
   task automatic write_max_age(input logic [AGE_W-1:0] value);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_max_age_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
      shadow_max_age  = value;
      age_writes++;
   endtask

   // -------------------------------------------------------------------------
   // Result checker: every strobe must match the oldest expected answer.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      range_answer_type exp_ans;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("result strobe with no item outstanding: hit %0b base %h size %h",
                   rsp_hit, rsp_found_base, rsp_found_size);
            mismatch_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            answers_checked++;
            if (rsp_hit !== exp_ans.hit) begin
               $error("hit mismatch: expected %0b, actual %0b", exp_ans.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_found_base !== exp_ans.base) begin
               $error("found_base mismatch: expected %h, actual %h",
                      exp_ans.base, rsp_found_base);
               mismatch_count++;
            end
            if (rsp_found_size !== exp_ans.size) begin
               $error("found_size mismatch: expected %h, actual %h",
                      exp_ans.size, rsp_found_size);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any accepted item, result or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("testbench: errors");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Directed tests
   // -------------------------------------------------------------------------

   // Fresh cache: every lookup misses, zero key included.
   task automatic test_empty_cache();
      send_item(OP_LOOKUP, KEY_A, RANGE_TOP, RANGE_TOP, 63'd100);
      send_item(OP_LOOKUP, '0, '0, '0, 63'd100);
   endtask

   // Zero key, base or size: store is dropped, pointer stays put.
   task automatic test_invalid_stores();
      send_item(OP_STORE, '0, 64'h1000, 64'h10, 63'd200);
      send_item(OP_STORE, KEY_A, '0, 64'h10, 63'd200);
      send_item(OP_STORE, KEY_A, 64'h1000, '0, 63'd200);
      send_item(OP_LOOKUP, KEY_A, '0, '0, 63'd200);
   endtask

   // Freshness window under the reset max age (2000 ticks).
   task automatic test_freshness_window();
      // store at tick zero is kept but reads as empty
      send_item(OP_STORE, KEY_B, 64'h2000, 64'h20, '0);
      send_item(OP_LOOKUP, KEY_B, '0, '0, '0);
      send_item(OP_STORE, KEY_TOP, RANGE_TOP, RANGE_TOP, 63'd1000);
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd1000);      // age zero
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd3000);      // age at the limit
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd3001);      // one past it
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd999);       // stamp in the future
      send_item(OP_STORE, KEY_TOP, 64'hDEAD_0000_BEEF_0000, 64'h0123_4567_89AB_CDEF,
                63'd1500);
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd2000);      // lower slot wins
      send_item(OP_LOOKUP, KEY_TOP, '0, '0, 63'd3200);      // only the newer is fresh
      send_item(OP_LOOKUP, 32'h0000_0001, '0, '0, 63'd1500);
   endtask

   // Max age at zero, then at all ones; ages wider than the register.
   task automatic test_age_register_extremes();
      write_max_age('0);
      send_item(OP_STORE, KEY_C, 64'h1, 64'h1, NOW_TOP - 63'd1);
      send_item(OP_LOOKUP, KEY_C, '0, '0, NOW_TOP - 63'd1);
      send_item(OP_LOOKUP, KEY_C, '0, '0, NOW_TOP);
      write_max_age('1);
      send_item(OP_STORE, KEY_A, 64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0000, 63'd5);
      send_item(OP_LOOKUP, KEY_A, '0, '0, NOW_W'(64'h1_0000_0004));
      send_item(OP_LOOKUP, KEY_A, '0, '0, NOW_W'(64'h1_0000_0005));
      send_item(OP_LOOKUP, KEY_C, '0, '0, NOW_TOP);
   endtask

   // -------------------------------------------------------------------------
   // Random phase: keys from a small pool so lookups hit, time creeping
   // forward at a pace tied to the max age so entries age in and out.
   // -------------------------------------------------------------------------
   task automatic test_random_phase(input logic [AGE_W-1:0] age_value, input int count);
      logic [KEY_W-1:0]   key_pool [6];
      logic [KEY_W-1:0]   key;
      logic [RANGE_W-1:0] base;
      logic [RANGE_W-1:0] size;
      logic [NOW_W-1:0]   now;
      logic               op;
      int unsigned        step_cap;
      int                 roll;
      write_max_age(age_value);
      foreach (key_pool[k]) key_pool[k] = $urandom;
      tick_now = NOW_W'({$urandom_range(0, 255), $urandom}) + 63'd1;
      step_cap = (age_value >> 5) + 1;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0)
            quiet_stretch = ($urandom_range(0, 2) == 0);
         // time: rare jump anywhere, often unchanged, otherwise a small step
         roll = $urandom_range(0, 99);
         if (roll < 3)
            tick_now = NOW_W'({$urandom, $urandom});
         else if (roll >= 30)
            tick_now = tick_now + NOW_W'($urandom_range(0, step_cap));
         now = tick_now;
         if ($urandom_range(0, 19) == 0)
            now = tick_now - NOW_W'($urandom_range(1, step_cap));   // look back in time
         roll = $urandom_range(0, 99);
         if (roll < 85)
            key = key_pool[$urandom_range(0, 5)];
         else if (roll < 95)
            key = $urandom;
         else
            key = '0;
         op   = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_LOOKUP;
         base = {$urandom, $urandom};
         size = {$urandom, $urandom};
         if (op == OP_STORE) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
               base = '0;
            else if (roll < 8)
               size = '0;
         end
         send_item(op, key, base, size, now);
      end
      quiet_stretch = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      foreach (shadow_key[i]) begin
         shadow_key[i]   = '0;
         shadow_base[i]  = '0;
         shadow_size[i]  = '0;
         shadow_stamp[i] = '0;
      end
      shadow_next    = 0;
      shadow_max_age = MAX_AGE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_cache();
      test_invalid_stores();
      test_freshness_window();
      test_age_register_extremes();

      test_random_phase(MAX_AGE_RESET, 270);
      test_random_phase('0, 270);
      test_random_phase('1, 270);
      test_random_phase(32'd1, 270);
      test_random_phase(AGE_W'($urandom_range(2, 5000)), 270);
      test_random_phase(AGE_W'($urandom), 270);

      // drain, then wait out a full scan for stray strobes
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (ENTRIES + 20) @(posedge clock);

      $display("covered %0d stores written, %0d stores dropped, %0d lookups (%0d hits)",
               stores_written, stores_dropped, lookups_issued, lookups_hit);
      $display("%0d results checked across %0d max age settings",
               answers_checked, age_writes);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
